// File: hdl/b64e_pkg.sv
// Shared types, constants and the sextet-to-character map of the Base64 stream encoder.
// Used by every module of the encoder; depends on nothing.

package b64e_pkg;

  localparam int CharW       = 7;
  localparam int SextetW     = 6;
  localparam int MaxChars    = 4;
  localparam int SlotW       = $clog2(MaxChars);
  localparam int QueueDepthDefault = 2;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  localparam logic [SextetW-1:0] LAST_UPPER = 6'd25;
  localparam logic [SextetW-1:0] LAST_LOWER = 6'd51;
  localparam logic [SextetW-1:0] LAST_DIGIT = 6'd61;
  localparam logic [SextetW-1:0] CODE_PLUS  = 6'd62;

  localparam logic [CharW-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CharW-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CharW-1:0] CHAR_PLUS    = 7'h2B;
  localparam logic [CharW-1:0] CHAR_SLASH   = 7'h2F;
  localparam logic [CharW-1:0] CHAR_PAD     = 7'h3D;

  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [SlotW-1:0]               last_slot;
    logic                           fin;
  } job_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] w;
    logic [CharW-1:0] r;
    begin
      w = {1'b0, v};
      if (v <= LAST_UPPER) begin
        r = CHAR_UPPER_A + w;
      end else if (v <= LAST_LOWER) begin
        r = CHAR_LOWER_A + w - CharW'(LAST_UPPER + 6'd1);
      end else if (v <= LAST_DIGIT) begin
        r = CHAR_ZERO + w - CharW'(LAST_LOWER + 6'd1);
      end else if (v == CODE_PLUS) begin
        r = CHAR_PLUS;
      end else begin
        r = CHAR_SLASH;
      end
      return r;
    end
  endfunction

endpackage

// File: hdl/b64e_stream_if.sv
// Valid/ready stream interfaces for raw bytes in and Base64 characters out.
// Depends on nothing.

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
  modport monitor (input valid, input ready, input in_byte, input final_byte);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_char, output run_end, output message_end,
                  input ready);
  modport sink (input valid, input out_char, input run_end, input message_end,
                output ready);
  modport monitor (input valid, input ready, input out_char, input run_end,
                   input message_end);
endinterface

// File: hdl/base64_stream_encoder.sv
// Base64 stream encoder top level: front end, job queue and back end.
// Depends on b64e_pkg, the stream interfaces, b64e_front, b64e_queue and b64e_back.

// Raw bytes enter on raw and standard Base64 characters leave on enc, one character per
// cycle while enc.ready is high. A byte is taken at the input whenever the job queue has
// room; on the output it yields one or two characters in a running message, and three or
// four for a final byte that leaves a partial group, which is flushed and padded with '='.
// The sustained rate is therefore set by the back end's single character per cycle. run_end
// marks the last character of each byte and message_end the last character of a byte
// flagged final_byte, after which the next byte starts a fresh group.

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  b64e_byte_if.sink    raw,
  b64e_char_if.source  enc
);
  import b64e_pkg::*;

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t head;
  logic head_valid;
  logic pop;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .enc        (enc)
  );

endmodule

// File: hdl/b64e_front.sv
// Front end: accepts raw bytes, tracks the group phase and carried bits, and builds a job
// of up to four characters per byte. Depends on b64e_pkg and b64e_byte_if.

module b64e_front (
  input  logic            clk,
  input  logic            rst,
  b64e_byte_if.sink       raw,
  output b64e_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_ready
);
  import b64e_pkg::*;

  logic [1:0]         phase;
  logic [1:0]         phase_next;
  logic [SextetW-1:0] carry_bits;
  logic [SextetW-1:0] carry_next;
  logic [SextetW-1:0] first_sextet;
  logic               accept;

  assign job_valid = raw.valid;
  assign raw.ready = job_ready;
  assign accept    = raw.valid && job_ready;

  always_comb begin
    unique case (phase)
      PH_ONE: begin
        first_sextet = carry_bits | SextetW'(raw.in_byte[7:4]);
        carry_next   = {raw.in_byte[3:0], 2'b00};
        phase_next   = PH_TWO;
      end
      PH_TWO: begin
        first_sextet = carry_bits | SextetW'(raw.in_byte[7:6]);
        carry_next   = '0;
        phase_next   = PH_START;
      end
      default: begin
        first_sextet = raw.in_byte[7:2];
        carry_next   = {raw.in_byte[1:0], 4'b0000};
        phase_next   = PH_ONE;
      end
    endcase
  end

  always_comb begin
    job.chars[0] = sextet_char(first_sextet);
    job.chars[1] = (phase == PH_TWO) ? sextet_char(raw.in_byte[5:0])
                                     : sextet_char(carry_next);
    job.chars[2] = CHAR_PAD;
    job.chars[3] = CHAR_PAD;
    job.fin      = raw.final_byte;
    if (phase == PH_TWO) begin
      job.last_slot = SlotW'(1);
    end else if (!raw.final_byte) begin
      job.last_slot = SlotW'(0);
    end else if (phase_next == PH_ONE) begin
      job.last_slot = SlotW'(3);
    end else begin
      job.last_slot = SlotW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      carry_bits <= '0;
    end else if (accept) begin
      if (raw.final_byte) begin
        phase      <= PH_START;
        carry_bits <= '0;
      end else begin
        phase      <= phase_next;
        carry_bits <= carry_next;
      end
    end
  end

endmodule

// File: hdl/b64e_queue.sv
// Short job queue between the front and back ends, so that each side stalls on its own.
// Depends on b64e_pkg.

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  b64e_pkg::job_t  push_job,
  input  logic            push_valid,
  output logic            push_ready,
  output b64e_pkg::job_t  head,
  output logic            head_valid,
  input  logic            pop
);
  import b64e_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  assign push_ready = (count != CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: hdl/b64e_back.sv
// Back end: walks the job at the queue head a character a cycle while enc.ready is high, and
// marks the end of each byte's run and of the message. Depends on b64e_pkg and b64e_char_if.

module b64e_back (
  input  logic            clk,
  input  logic            rst,
  input  b64e_pkg::job_t  head,
  input  logic            head_valid,
  output logic            pop,
  b64e_char_if.source     enc
);
  import b64e_pkg::*;

  logic [SlotW-1:0] slot;
  logic             last;
  logic             fire;

  assign last            = (slot == head.last_slot);
  assign fire            = head_valid && enc.ready;
  assign pop             = fire && last;
  assign enc.valid       = head_valid;
  assign enc.out_char    = head.chars[slot];
  assign enc.run_end     = last;
  assign enc.message_end = last && head.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (pop) begin
      slot <= '0;
    end else if (fire) begin
      slot <= slot + SlotW'(1);
    end
  end

endmodule

// File: hdl/b64e_checker.sv
// Port-level checks on the encoder's character output, attached to the top level by bind.
// Depends on base64_stream_encoder, whose enc port signals are handed in by the bind.

module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [6:0] out_char,
  input logic       run_end,
  input logic       message_end
);

  property p_end_marks;
    @(posedge clk) disable iff (rst)
      (valid && message_end) |-> run_end;
  endproperty
  a_end_marks: assert property (p_end_marks) else $error("message end without run end");

  property p_legal_char;
    @(posedge clk) disable iff (rst)
      valid |-> ((out_char >= 7'h41 && out_char <= 7'h5A) ||
                 (out_char >= 7'h61 && out_char <= 7'h7A) ||
                 (out_char >= 7'h30 && out_char <= 7'h39) ||
                 out_char == 7'h2B || out_char == 7'h2F ||
                 out_char == 7'h3D);
  endproperty
  a_legal_char: assert property (p_legal_char) else $error("illegal output character");

  property p_pad_ends_message;
    @(posedge clk) disable iff (rst)
      (valid && out_char == 7'h3D && run_end) |-> message_end;
  endproperty
  a_pad_ends_message: assert property (p_pad_ends_message)
    else $error("padding closes a byte without closing the message");

  property p_empty_after_reset;
    @(posedge clk) $past(rst) |-> !valid;
  endproperty
  a_empty_after_reset: assert property (p_empty_after_reset)
    else $error("output request straight after reset");

  property p_hold_stalled;
    @(posedge clk) disable iff (rst)
      (valid && !ready) |=> (valid && $stable(out_char));
  endproperty
  a_hold_stalled: assert property (p_hold_stalled) else $error("stalled request changed");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (enc.valid),
  .ready       (enc.ready),
  .out_char    (enc.out_char),
  .run_end     (enc.run_end),
  .message_end (enc.message_end)
);

// File: test/tb_top.sv
// Self-checking testbench for base64_stream_encoder: a directed table of requests, then
// random messages, checked against table chars or a behavioural encoder kept in step.
// Depends on b64e_pkg, the stream interfaces in b64e_stream_if.sv and the encoder RTL.

module tb_top;
  import b64e_pkg::*;

  localparam int RandomBytes = 360;
  localparam int StallLimit  = 2000;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             run_end;
    logic             msg_end;
  } enc_char_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic [31:0] chars;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  logic [1:0]         grp_phase = PH_START;
  logic [SextetW-1:0] pend_bits = '0;
  enc_char_t          step_chars[$];
  enc_char_t          char_fifo[$];
  logic [31:0]        offered[$];
  int                 n_errors = 0;
  int                 quiet_cycles = 0;
  bit                 burst_mode = 1'b0;

  // A non-zero chars field holds the expected characters, first one in the highest non-zero byte.
  stim_row_t dir_tab [22] = '{
    '{8'h00, 1'b1, "AA=="},
    '{8'hFF, 1'b1, "/w=="},
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b0, "W"},
    '{8'h6E, 1'b1, "Fu"},
    '{8'h4D, 1'b0, "T"},
    '{8'h61, 1'b1, "WE="},
    '{8'hFB, 1'b0, 32'h0},
    '{8'hEF, 1'b0, 32'h0},
    '{8'hBE, 1'b1, 32'h0},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b0, "/"},
    '{8'hFF, 1'b0, "//"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b0, "A"},
    '{8'h00, 1'b0, "AA"},
    '{8'hD3, 1'b0, 32'h0},
    '{8'h5D, 1'b0, 32'h0},
    '{8'hB7, 1'b1, 32'h0},
    '{8'h80, 1'b1, "gA=="},
    '{8'h01, 1'b0, "A"},
    '{8'h02, 1'b1, "QI="}
  };

  b64e_byte_if raw_if ();
  b64e_char_if enc_if ();

  base64_stream_encoder u_dut (
    .clk (clk),
    .rst (rst),
    .raw (raw_if.sink),
    .enc (enc_if.source)
  );

  always #10 clk = ~clk;

  function automatic logic [CharW-1:0] b64_char(input logic [SextetW-1:0] s);
    if (s < 6'd26) return CHAR_UPPER_A + CharW'(s);
    if (s < 6'd52) return CHAR_LOWER_A + CharW'(s - 6'd26);
    if (s < 6'd62) return CHAR_ZERO + CharW'(s - 6'd52);
    if (s == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic void push_char(input logic [CharW-1:0] c);
    enc_char_t e;
    e.ch      = c;
    e.run_end = 1'b0;
    e.msg_end = 1'b0;
    step_chars.push_back(e);
  endfunction

  function automatic void mark_last(input logic fin);
    enc_char_t e;
    e = step_chars.pop_back();
    e.run_end = 1'b1;
    e.msg_end = fin;
    step_chars.push_back(e);
  endfunction

  // Encodes one byte into step_chars and advances the group phase and pending bits.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int pads;
    step_chars = {};
    pads = 0;
    case (grp_phase)
      PH_ONE: begin
        push_char(b64_char(pend_bits | {2'b00, b[7:4]}));
        pend_bits = {b[3:0], 2'b00};
        grp_phase = PH_TWO;
      end
      PH_TWO: begin
        push_char(b64_char(pend_bits | {4'b0000, b[7:6]}));
        push_char(b64_char(b[5:0]));
        pend_bits = '0;
        grp_phase = PH_START;
      end
      default: begin
        push_char(b64_char(b[7:2]));
        pend_bits = {b[1:0], 4'b0000};
        grp_phase = PH_ONE;
      end
    endcase
    if (fin) begin
      if (grp_phase != PH_START) begin
        pads = (grp_phase == PH_ONE) ? 2 : 1;
        push_char(b64_char(pend_bits));
        repeat (pads) push_char(CHAR_PAD);
      end
      grp_phase = PH_START;
      pend_bits = '0;
    end
    mark_last(fin);
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic fin, input logic [31:0] chars);
    while (!burst_mode && $urandom_range(99) < 32) begin
      raw_if.valid <= 1'b0;
      @(posedge clk);
    end
    offered.push_back(chars);
    raw_if.valid      <= 1'b1;
    raw_if.in_byte    <= b;
    raw_if.final_byte <= fin;
    @(posedge clk);
    while (!raw_if.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    logic [31:0] chars;
    enc_char_t   got;
    enc_char_t   want;
    bit          moved;
    moved = 1'b0;
    if (!rst) begin
      if (raw_if.valid && raw_if.ready) begin
        moved = 1'b1;
        chars = (offered.size() != 0) ? offered.pop_front() : 32'h0;
        encode_byte(raw_if.in_byte, raw_if.final_byte);
        if (chars != 32'h0) begin
          step_chars = {};
          for (int i = 3; i >= 0; i--) begin
            if (chars[8*i +: 8] != 8'h00) push_char(chars[8*i +: CharW]);
          end
          mark_last(raw_if.final_byte);
        end
        foreach (step_chars[k]) char_fifo.push_back(step_chars[k]);
      end
      if (enc_if.valid && enc_if.ready) begin
        moved = 1'b1;
        got.ch      = enc_if.out_char;
        got.run_end = enc_if.run_end;
        got.msg_end = enc_if.message_end;
        if (char_fifo.size() == 0) begin
          $error("unexpected result: out_char %h", got.ch);
          n_errors++;
        end else begin
          want = char_fifo.pop_front();
          if (got.ch !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, got.ch);
            n_errors++;
          end
          if (got.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, got.run_end);
            n_errors++;
          end
          if (got.msg_end !== want.msg_end) begin
            $error("message_end: expected %b, got %b", want.msg_end, got.msg_end);
            n_errors++;
          end
        end
      end
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Ready is random, but held low long to fill the block and later held high for a stretch.
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    enc_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) rx_cycles++;
      if (rx_cycles >= 300 && rx_cycles < 500) begin
        enc_if.ready <= 1'b0;
      end else if (rx_cycles >= 800 && rx_cycles < 1100) begin
        enc_if.ready <= 1'b1;
      end else begin
        enc_if.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    int sent;
    int len;
    sent = 0;
    raw_if.valid      <= 1'b0;
    raw_if.in_byte    <= 8'h00;
    raw_if.final_byte <= 1'b0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) offer_byte(dir_tab[k].b, dir_tab[k].fin, dir_tab[k].chars);

    while (sent < RandomBytes) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
      for (int j = 0; j < len; j++) begin
        burst_mode = (sent >= 150 && sent < 230);
        offer_byte(8'($urandom_range(255)), j == len - 1, 32'h0);
        sent++;
      end
    end
    raw_if.valid <= 1'b0;

    @(posedge clk);
    while (char_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
